/* rtl/bva_pkg.sv */
// ----------------------------------------------------------------------------
// bva_pkg
// shared types, opcodes and helpers of the bit-vector alu
// ----------------------------------------------------------------------------
package bva_pkg;

    localparam int DATA_W = 64;

    // opcodes
    localparam logic [4:0] CMD_ADD     = 5'd0;
    localparam logic [4:0] CMD_SUB     = 5'd1;
    localparam logic [4:0] CMD_MUL     = 5'd2;
    localparam logic [4:0] CMD_NEG     = 5'd3;
    localparam logic [4:0] CMD_UMUL    = 5'd4;
    localparam logic [4:0] CMD_SMUL    = 5'd5;
    localparam logic [4:0] CMD_UDIV    = 5'd6;
    localparam logic [4:0] CMD_SDIV    = 5'd7;
    localparam logic [4:0] CMD_UREM    = 5'd8;
    localparam logic [4:0] CMD_SREM    = 5'd9;
    localparam logic [4:0] CMD_AND     = 5'd10;
    localparam logic [4:0] CMD_OR      = 5'd11;
    localparam logic [4:0] CMD_XOR     = 5'd12;
    localparam logic [4:0] CMD_NOT     = 5'd13;
    localparam logic [4:0] CMD_ASHR    = 5'd14;
    localparam logic [4:0] CMD_LSHR    = 5'd15;
    localparam logic [4:0] CMD_SHL     = 5'd16;
    localparam logic [4:0] CMD_CONCAT  = 5'd17;
    localparam logic [4:0] CMD_ZEXT    = 5'd18;
    localparam logic [4:0] CMD_SEXT    = 5'd19;
    localparam logic [4:0] CMD_EXTRACT = 5'd20;
    localparam logic [4:0] CMD_EQ      = 5'd21;
    localparam logic [4:0] CMD_ULT     = 5'd22;
    localparam logic [4:0] CMD_ULE     = 5'd23;
    localparam logic [4:0] CMD_UGT     = 5'd24;
    localparam logic [4:0] CMD_UGE     = 5'd25;
    localparam logic [4:0] CMD_SLT     = 5'd26;
    localparam logic [4:0] CMD_SLE     = 5'd27;
    localparam logic [4:0] CMD_SGT     = 5'd28;
    localparam logic [4:0] CMD_SGE     = 5'd29;
    localparam logic [4:0] CMD_IS_ZERO = 5'd30;
    localparam logic [4:0] CMD_IS_ONE  = 5'd31;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // sideband that rides along the divider chain
    typedef struct packed {
        logic [4:0]        cmd;
        logic [6:0]        ow;
        logic              flag;
        logic [1:0]        status;
        logic              sa;
        logic              sb;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] value;
    } side_t;

    // low w bits set, all ones from DATA_W up
    function automatic logic [DATA_W-1:0] mask_of(input logic [6:0] w);
        logic [DATA_W:0] t;
        t = ({{DATA_W{1'b0}}, 1'b1} << w) - {{DATA_W{1'b0}}, 1'b1};
        return t[DATA_W-1:0];
    endfunction

endpackage

/* rtl/bva_divider.sv */
// ----------------------------------------------------------------------------
// bva_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bva_divider
    import bva_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_dvd,
    input  logic [DATA_W-1:0] in_dsr,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_quo,
    output logic [DATA_W-1:0] out_rem,
    output side_t             out_side
);

    logic              vld_reg  [1:DATA_W];
    logic [DATA_W-1:0] dq_reg   [1:DATA_W];
    logic [DATA_W-1:0] rem_reg  [1:DATA_W];
    logic [DATA_W-1:0] dsr_reg  [1:DATA_W];
    side_t             side_reg [1:DATA_W];

    // shift in the next dividend bit, try the subtract; gives {remainder, dividend/quotient}
    function automatic logic [2*DATA_W-1:0] div_step(
        input logic [DATA_W-1:0] rem_in,
        input logic [DATA_W-1:0] dq_in,
        input logic [DATA_W-1:0] dsr_in
    );
        logic [DATA_W:0] trial;
        logic [DATA_W:0] diff;
        logic            qbit;
        trial = {rem_in, dq_in[DATA_W-1]};
        diff  = trial - {1'b0, dsr_in};
        qbit  = ~diff[DATA_W];
        return {qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0], dq_in[DATA_W-2:0], qbit};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= DATA_W; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[1] <= in_valid;
            for (int k = 1; k < DATA_W; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            {rem_reg[1], dq_reg[1]} <= div_step('0, in_dvd, in_dsr);
            dsr_reg[1]  <= in_dsr;
            side_reg[1] <= in_side;
            for (int k = 1; k < DATA_W; k++) begin
                {rem_reg[k+1], dq_reg[k+1]} <= div_step(rem_reg[k], dq_reg[k], dsr_reg[k]);
                dsr_reg[k+1]  <= dsr_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[DATA_W];
    assign out_quo   = dq_reg[DATA_W];
    assign out_rem   = rem_reg[DATA_W];
    assign out_side  = side_reg[DATA_W];

endmodule

/* rtl/bitvector_alu_unit.sv */
// ----------------------------------------------------------------------------
// bitvector_alu_unit
// bit-vector alu for operands of run-time width 1 to 64, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+---------------------
//  s_      | cmd lhs rhs width rhs_width amount      | operation beat in
//          | high_bit low_bit                        |
//  m_      | value out_width flag status             | result beat out
//
//  one beat per cycle sustained while the output is not stalled; every beat walks
//  through the 64-stage restoring divider (one quotient bit a stage)
//  stages: decode, alu and partial products, multiply sum and magnitudes,
//  64 divide stages, result fixup and output register
//  aresetn clears all valid bits; payload registers are not reset
//  a stall at m_ready freezes the whole pipeline; s_ready follows it
//
module bitvector_alu_unit
    import bva_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // operation beat
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [4:0]        s_cmd,
    input  logic [63:0]       s_lhs,
    input  logic [63:0]       s_rhs,
    input  logic [6:0]        s_width,
    input  logic [5:0]        s_rhs_width,
    input  logic [6:0]        s_amount,
    input  logic [5:0]        s_high_bit,
    input  logic [5:0]        s_low_bit,
    // result beat
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_value,
    output logic [6:0]        m_out_width,
    output logic              m_flag,
    output logic [1:0]        m_status
);

    localparam logic [7:0] MAXW = 8'(MAX_WIDTH);

    // whole pipeline moves together; it advances when the output is free
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // stage 1: mask operands to width, sign bits and sign extension
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] m1, a1, b1;
    logic [6:0]        wm1;
    logic              sa1, sb1;

    always_comb begin
        m1  = mask_of(s_width);
        a1  = s_lhs & m1;
        b1  = s_rhs & m1;
        wm1 = s_width - 7'd1;
        sa1 = a1[wm1[5:0]];
        sb1 = b1[wm1[5:0]];
    end

    logic              v1_reg;
    logic [4:0]        cmd1_reg;
    logic [DATA_W-1:0] a1_reg, b1_reg, sxa1_reg, sxb1_reg, rb1_reg;
    logic [6:0]        w1_reg, amt1_reg;
    logic [5:0]        rw1_reg, hi1_reg, lo1_reg;
    logic              sa1_reg, sb1_reg, wok1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg <= s_cmd;
            a1_reg   <= a1;
            b1_reg   <= b1;
            sxa1_reg <= sa1 ? (a1 | ~m1) : a1;
            sxb1_reg <= sb1 ? (b1 | ~m1) : b1;
            // concat takes the low part straight from the raw operand
            rb1_reg  <= s_rhs & mask_of({1'b0, s_rhs_width});
            w1_reg   <= s_width;
            amt1_reg <= s_amount;
            rw1_reg  <= s_rhs_width;
            hi1_reg  <= s_high_bit;
            lo1_reg  <= s_low_bit;
            sa1_reg  <= sa1;
            sb1_reg  <= sb1;
            wok1_reg <= (s_width != 7'd0) && ({1'b0, s_width} <= MAXW);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: arithmetic, logic, shift and compare ops, size checks, multiplier partial products
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] val2, ma2, mb2, ashr2;
    logic [6:0]        ow2;
    logic              flag2, mul2;
    logic [1:0]        st2;
    logic [63:0]       pp0, pp1, pp2;

    always_comb begin
        val2  = '0;
        ow2   = w1_reg;
        flag2 = 1'b0;
        st2   = ST_OK;
        mul2  = 1'b0;
        // sign-extended operand shifted right gives the sign copies
        ashr2 = $signed(sxa1_reg) >>> amt1_reg;
        unique case (cmd1_reg)
            CMD_ADD:  val2 = a1_reg + b1_reg;
            CMD_SUB:  val2 = a1_reg - b1_reg;
            CMD_MUL:  mul2 = 1'b1;
            CMD_NEG:  val2 = '0 - a1_reg;
            CMD_UMUL, CMD_SMUL: begin
                mul2 = 1'b1;
                ow2  = {w1_reg[5:0], 1'b0};
                if ({w1_reg, 1'b0} > MAXW) st2 = ST_BAD;
            end
            CMD_UDIV, CMD_SDIV, CMD_UREM, CMD_SREM: begin
                if (b1_reg == '0) st2 = ST_DIVZ;
            end
            CMD_AND:  val2 = a1_reg & b1_reg;
            CMD_OR:   val2 = a1_reg | b1_reg;
            CMD_XOR:  val2 = a1_reg ^ b1_reg;
            CMD_NOT:  val2 = ~a1_reg;
            CMD_ASHR: val2 = (amt1_reg >= w1_reg) ? (sa1_reg ? '1 : '0) : ashr2;
            CMD_LSHR: val2 = (amt1_reg >= w1_reg) ? '0 : (a1_reg >> amt1_reg);
            CMD_SHL:  val2 = (amt1_reg >= w1_reg) ? '0 : (a1_reg << amt1_reg);
            CMD_CONCAT: begin
                ow2  = w1_reg + {1'b0, rw1_reg};
                val2 = (a1_reg << rw1_reg) | rb1_reg;
                if (rw1_reg == 6'd0 || ({1'b0, w1_reg} + {2'b0, rw1_reg}) > MAXW)
                    st2 = ST_BAD;
            end
            CMD_ZEXT, CMD_SEXT: begin
                ow2  = amt1_reg;
                val2 = (cmd1_reg == CMD_ZEXT) ? a1_reg : sxa1_reg;
                if (amt1_reg < w1_reg || {1'b0, amt1_reg} > MAXW) st2 = ST_BAD;
            end
            CMD_EXTRACT: begin
                ow2  = {1'b0, hi1_reg} - {1'b0, lo1_reg} + 7'd1;
                val2 = a1_reg >> lo1_reg;
                if (hi1_reg < lo1_reg || {1'b0, hi1_reg} >= w1_reg) st2 = ST_BAD;
            end
            CMD_EQ:      flag2 = (a1_reg == b1_reg);
            CMD_ULT:     flag2 = (a1_reg <  b1_reg);
            CMD_ULE:     flag2 = (a1_reg <= b1_reg);
            CMD_UGT:     flag2 = (a1_reg >  b1_reg);
            CMD_UGE:     flag2 = (a1_reg >= b1_reg);
            CMD_SLT:     flag2 = ($signed(sxa1_reg) <  $signed(sxb1_reg));
            CMD_SLE:     flag2 = ($signed(sxa1_reg) <= $signed(sxb1_reg));
            CMD_SGT:     flag2 = ($signed(sxa1_reg) >  $signed(sxb1_reg));
            CMD_SGE:     flag2 = ($signed(sxa1_reg) >= $signed(sxb1_reg));
            CMD_IS_ZERO: flag2 = (a1_reg == '0);
            CMD_IS_ONE:  flag2 = (a1_reg == 64'd1);
            default:     val2 = '0;
        endcase
        if (cmd1_reg >= CMD_EQ) begin
            val2 = {{(DATA_W-1){1'b0}}, flag2};
            ow2  = 7'd1;
        end
        if (!wok1_reg) st2 = ST_BAD;

        // smul works on the sign-extended operands, low half is exact
        ma2 = (cmd1_reg == CMD_SMUL) ? sxa1_reg : a1_reg;
        mb2 = (cmd1_reg == CMD_SMUL) ? sxb1_reg : b1_reg;
        pp0 = {32'd0, ma2[31:0]}  * {32'd0, mb2[31:0]};
        pp1 = {32'd0, ma2[31:0]}  * {32'd0, mb2[63:32]};
        pp2 = {32'd0, ma2[63:32]} * {32'd0, mb2[31:0]};
    end

    logic              v2_reg, mul2_reg;
    logic [DATA_W-1:0] a2_reg, b2_reg;
    logic [6:0]        w2_reg;
    logic [63:0]       pp0_reg;
    logic [31:0]       pp1_reg, pp2_reg;
    side_t             side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul2_reg         <= mul2;
            a2_reg           <= a1_reg;
            b2_reg           <= b1_reg;
            w2_reg           <= w1_reg;
            pp0_reg          <= pp0;
            pp1_reg          <= pp1[31:0];
            pp2_reg          <= pp2[31:0];
            side2_reg.cmd    <= cmd1_reg;
            side2_reg.ow     <= ow2;
            side2_reg.flag   <= flag2;
            side2_reg.status <= st2;
            side2_reg.sa     <= sa1_reg;
            side2_reg.sb     <= sb1_reg;
            side2_reg.a      <= a1_reg;
            side2_reg.value  <= val2;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: product sum, divide operands (magnitudes for signed ops)
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] prod3, m3, dvd3, dsr3;
    logic [31:0]       cross3;
    logic              sgn3;
    side_t             side3;

    always_comb begin
        cross3 = pp1_reg + pp2_reg;
        prod3  = pp0_reg + {cross3, 32'd0};
        m3     = mask_of(w2_reg);
        sgn3   = (side2_reg.cmd == CMD_SDIV) || (side2_reg.cmd == CMD_SREM);
        dvd3   = (sgn3 && side2_reg.sa) ? (('0 - a2_reg) & m3) : a2_reg;
        dsr3   = (sgn3 && side2_reg.sb) ? (('0 - b2_reg) & m3) : b2_reg;
        side3  = side2_reg;
        if (mul2_reg) side3.value = prod3;
    end

    logic              v3_reg;
    logic [DATA_W-1:0] dvd3_reg, dsr3_reg;
    side_t             side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd3_reg  <= dvd3;
            dsr3_reg  <= dsr3;
            side3_reg <= side3;
        end
    end

    // ------------------------------------------------------------------
    // divide stages; every beat walks through them to keep order
    // ------------------------------------------------------------------
    logic              vd;
    logic [DATA_W-1:0] quo, rem;
    side_t             sd;

    bva_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_dvd    (dvd3_reg),
        .in_dsr    (dsr3_reg),
        .in_side   (side3_reg),
        .out_valid (vd),
        .out_quo   (quo),
        .out_rem   (rem),
        .out_side  (sd)
    );

    // ------------------------------------------------------------------
    // final stage: quotient/remainder sign fixup, divide-by-zero values,
    // masking to result width and clearing of bad results
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] mo, val_f;
    logic [6:0]        ow_f;
    logic              flag_f;
    logic              divz;

    always_comb begin
        mo     = mask_of(sd.ow);
        val_f  = sd.value;
        ow_f   = sd.ow;
        flag_f = sd.flag;
        divz   = (sd.status == ST_DIVZ);
        unique case (sd.cmd)
            CMD_UDIV: val_f = divz ? mo : quo;
            CMD_UREM: val_f = divz ? sd.a : rem;
            CMD_SDIV: begin
                if (divz) val_f = sd.sa ? {{(DATA_W-1){1'b0}}, 1'b1} : mo;
                else      val_f = (sd.sa != sd.sb) ? ('0 - quo) : quo;
            end
            CMD_SREM: begin
                if (divz) val_f = sd.a;
                else      val_f = sd.sa ? ('0 - rem) : rem;
            end
            default:  val_f = sd.value;
        endcase
        val_f = val_f & mo;
        if (sd.status == ST_BAD) begin
            val_f  = '0;
            ow_f   = 7'd0;
            flag_f = 1'b0;
        end
    end

    logic              vo_reg;
    logic [DATA_W-1:0] val_o_reg;
    logic [6:0]        ow_o_reg;
    logic              flag_o_reg;
    logic [1:0]        st_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_o_reg  <= val_f;
            ow_o_reg   <= ow_f;
            flag_o_reg <= flag_f;
            st_o_reg   <= sd.status;
        end
    end

    assign m_valid     = vo_reg;
    assign m_value     = val_o_reg;
    assign m_out_width = ow_o_reg;
    assign m_flag      = flag_o_reg;
    assign m_status    = st_o_reg;

endmodule

/* rtl/bva_checker.sv */
// ----------------------------------------------------------------------------
// bva_checker
// port-level checks of the bit-vector alu
// ----------------------------------------------------------------------------
module bva_checker
    import bva_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_value,
    input logic [6:0]  m_out_width,
    input logic        m_flag,
    input logic [1:0]  m_status
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("stalled result beat changed");

    // input is taken exactly when the output stage can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready out of step with output stage");

    // bad size results are all zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_BAD |-> m_value == 64'd0 && m_out_width == 7'd0
            && !m_flag)
        else $error("bad size result not cleared");

    // a true flag is a one-bit result of one
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flag |-> m_value == 64'd1 && m_out_width == 7'd1)
        else $error("flag result malformed");

endmodule

bind bitvector_alu_unit bva_checker u_bva_checker (.*);

/* tb/bitvector_alu_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitvector_alu_unit_tb
// drives directed and random operations through the alu and compares every
// result beat against an in-bench model of the bit-vector semantics
// ----------------------------------------------------------------------------
module bitvector_alu_unit_tb
    import bva_pkg::*;
();

    // one operation beat
    typedef struct {
        logic [4:0]  cmd;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [6:0]  width;
        logic [5:0]  rhs_width;
        logic [6:0]  amount;
        logic [5:0]  high_bit;
        logic [5:0]  low_bit;
    } op_t;

    // one result beat
    typedef struct {
        logic [63:0] value;
        logic [6:0]  out_width;
        logic        flag;
        logic [1:0]  status;
    } res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [4:0]  s_cmd = '0;
    logic [63:0] s_lhs = '0;
    logic [63:0] s_rhs = '0;
    logic [6:0]  s_width = 7'd1;
    logic [5:0]  s_rhs_width = '0;
    logic [6:0]  s_amount = '0;
    logic [5:0]  s_high_bit = '0;
    logic [5:0]  s_low_bit = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_value;
    logic [6:0]  m_out_width;
    logic        m_flag;
    logic [1:0]  m_status;

    op_t  pending_ops[$];
    res_t expected_results[$];
    int   mismatch_count = 0;
    int   ops_sent = 0;
    int   results_seen = 0;
    int   send_idle_pct = 21;
    int   recv_idle_pct = 83;

    bitvector_alu_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_lhs(s_lhs),
        .s_rhs(s_rhs), .s_width(s_width), .s_rhs_width(s_rhs_width),
        .s_amount(s_amount), .s_high_bit(s_high_bit), .s_low_bit(s_low_bit),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_out_width(m_out_width), .m_flag(m_flag), .m_status(m_status)
    );

    always #10 aclk = ~aclk;

    function automatic logic [63:0] low_mask(input int w);
        if (w >= 64) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [63:0] sign_extend(input logic [63:0] v, input int w);
        if (w >= 64) return v;
        return v[w-1] ? (v | ~low_mask(w)) : v;
    endfunction

    // bit-exact expectation for one operation
    function automatic res_t alu_result(input op_t op);
        res_t r;
        logic [63:0] a, b, m, ma, mb, q, ka, kb;
        logic sa, sb, is_cmp;
        int w, rw, amt;
        r = '{value: '0, out_width: '0, flag: 1'b0, status: ST_OK};
        w = op.width; rw = op.rhs_width; amt = op.amount;
        is_cmp = 1'b0;
        if (w < 1 || w > 64) begin
            r.status = ST_BAD;
            return r;
        end
        m = low_mask(w);
        a = op.lhs & m;
        b = op.rhs & m;
        sa = a[w-1];
        sb = b[w-1];
        r.out_width = w[6:0];
        ka = sign_extend(a, w) ^ (64'd1 << 63);
        kb = sign_extend(b, w) ^ (64'd1 << 63);
        ma = sa ? ((64'd0 - a) & m) : a;
        mb = sb ? ((64'd0 - b) & m) : b;
        case (op.cmd)
            CMD_ADD: r.value = a + b;
            CMD_SUB: r.value = a - b;
            CMD_MUL: r.value = a * b;
            CMD_NEG: r.value = 64'd0 - a;
            CMD_UMUL, CMD_SMUL: begin
                if (2 * w > 64) r.status = ST_BAD;
                else begin
                    r.out_width = 7'(2 * w);
                    r.value = (op.cmd == CMD_UMUL) ? a * b
                            : sign_extend(a, w) * sign_extend(b, w);
                end
            end
            CMD_UDIV, CMD_UREM: begin
                if (b == 0) begin
                    r.status = ST_DIVZ;
                    r.value = (op.cmd == CMD_UDIV) ? m : a;
                end else r.value = (op.cmd == CMD_UDIV) ? a / b : a % b;
            end
            CMD_SDIV, CMD_SREM: begin
                if (b == 0) begin
                    r.status = ST_DIVZ;
                    if (op.cmd == CMD_SDIV) r.value = sa ? 64'd1 : m;
                    else r.value = a;
                end else if (op.cmd == CMD_SDIV) begin
                    q = ma / mb;
                    r.value = (sa != sb) ? 64'd0 - q : q;
                end else begin
                    q = ma % mb;
                    r.value = sa ? 64'd0 - q : q;
                end
            end
            CMD_AND: r.value = a & b;
            CMD_OR:  r.value = a | b;
            CMD_XOR: r.value = a ^ b;
            CMD_NOT: r.value = ~a;
            CMD_ASHR: begin
                if (amt >= w) r.value = sa ? m : '0;
                else r.value = $signed(sign_extend(a, w)) >>> amt;
            end
            CMD_LSHR: r.value = (amt >= w) ? '0 : (a >> amt);
            CMD_SHL:  r.value = (amt >= w) ? '0 : (a << amt);
            CMD_CONCAT: begin
                if (rw == 0 || w + rw > 64) r.status = ST_BAD;
                else begin
                    r.out_width = 7'(w + rw);
                    r.value = (a << rw) | (op.rhs & low_mask(rw));
                end
            end
            CMD_ZEXT, CMD_SEXT: begin
                if (amt < w || amt > 64) r.status = ST_BAD;
                else begin
                    r.out_width = 7'(amt);
                    r.value = (op.cmd == CMD_ZEXT) ? a : sign_extend(a, w);
                end
            end
            CMD_EXTRACT: begin
                if (op.high_bit < op.low_bit || op.high_bit >= w) r.status = ST_BAD;
                else begin
                    r.out_width = 7'(op.high_bit - op.low_bit + 1);
                    r.value = a >> op.low_bit;
                end
            end
            default: begin
                is_cmp = 1'b1;
                case (op.cmd)
                    CMD_EQ:      r.flag = (a == b);
                    CMD_ULT:     r.flag = (a < b);
                    CMD_ULE:     r.flag = (a <= b);
                    CMD_UGT:     r.flag = (a > b);
                    CMD_UGE:     r.flag = (a >= b);
                    CMD_SLT:     r.flag = (ka < kb);
                    CMD_SLE:     r.flag = (ka <= kb);
                    CMD_SGT:     r.flag = (ka > kb);
                    CMD_SGE:     r.flag = (ka >= kb);
                    CMD_IS_ZERO: r.flag = (a == 0);
                    default:     r.flag = (a == 1);
                endcase
                r.value = {63'd0, r.flag};
                r.out_width = 7'd1;
            end
        endcase
        if (r.status == ST_BAD) begin
            r.value = '0;
            r.out_width = '0;
            r.flag = 1'b0;
        end else if (!is_cmp) begin
            r.value &= low_mask(r.out_width);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch on result %0d: %s got %h expected %h",
                 results_seen, what, got, want);
    endtask

    // append one operation to the pending list
    task automatic queue_op(input op_t op);
        pending_ops = {pending_ops, op};
    endtask

    // driver: one beat per accepted handshake, random gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    op_t op;
                    op = pending_ops.pop_front();
                    expected_results = {expected_results, alu_result(op)};
                    s_valid <= 1'b1;
                    s_cmd <= op.cmd;
                    s_lhs <= op.lhs;
                    s_rhs <= op.rhs;
                    s_width <= op.width;
                    s_rhs_width <= op.rhs_width;
                    s_amount <= op.amount;
                    s_high_bit <= op.high_bit;
                    s_low_bit <= op.low_bit;
                    ops_sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            res_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", m_value, 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_value !== want.value)
                    report_mismatch("value", m_value, want.value);
                if (m_out_width !== want.out_width)
                    report_mismatch("out_width", m_out_width, want.out_width);
                if (m_flag !== want.flag)
                    report_mismatch("flag", m_flag, want.flag);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
            end
            results_seen++;
        end
    end

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1;
            3: v = 64'd1 << $urandom_range(63);
            default: ;
        endcase
        return v;
    endfunction

    function automatic op_t make_op(input logic [4:0] cmd, input logic [63:0] a,
                                    input logic [63:0] b, input int w);
        op_t op;
        op.cmd = cmd; op.lhs = a; op.rhs = b; op.width = 7'(w);
        op.rhs_width = 6'($urandom_range(63));
        op.amount = 7'($urandom_range(127));
        op.high_bit = 6'($urandom_range(63));
        op.low_bit = 6'($urandom_range(63));
        return op;
    endfunction

    function automatic op_t random_op();
        op_t op;
        int w;
        // mostly legal widths, some out of range
        w = ($urandom_range(19) == 0) ? (($urandom_range(1) == 0) ? 0 : $urandom_range(65, 127))
          : ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 64 : 1)
          : $urandom_range(1, 64);
        op = make_op(5'($urandom_range(31)), rand64(), rand64(), w);
        if ($urandom_range(3) == 0) op.rhs = '0;
        if (w >= 1 && w <= 64 && $urandom_range(2) != 0) begin
            // well-formed size fields most of the time
            op.amount = 7'($urandom_range(w, 64));
            if (op.cmd <= CMD_SHL && $urandom_range(1)) op.amount = 7'($urandom_range(w + 1));
            op.high_bit = 6'($urandom_range(w - 1));
            op.low_bit = 6'($urandom_range(op.high_bit));
            if (w < 64) op.rhs_width = 6'($urandom_range(1, 64 - w));
        end
        return op;
    endfunction

    initial begin
        logic [4:0] c;
        op_t op;
        // directed: extremes and corner cases
        for (int k = 0; k < 32; k += 2) begin
            c = 5'(k);
            queue_op(make_op(c, '1, '1, 64));
            queue_op(make_op(c + 5'd1, 64'h8000_0000_0000_0000, '0, 64));
        end
        queue_op(make_op(CMD_SDIV, 64'h80, 64'hff, 8));
        queue_op(make_op(CMD_SREM, 64'h85, 64'h03, 8));
        queue_op(make_op(CMD_UDIV, 64'h5, 64'h0, 0));
        op = make_op(CMD_SEXT, 64'h8000_0000, 0, 32); op.amount = 7'd64;
        queue_op(op);
        op = make_op(CMD_ASHR, 64'h80, 0, 8); op.amount = 7'd127;
        queue_op(op);
        op = make_op(CMD_CONCAT, '1, '1, 32); op.rhs_width = 6'd32;
        queue_op(op);
        op = make_op(CMD_EXTRACT, '1, 0, 64); op.high_bit = 6'd63; op.low_bit = 6'd0;
        queue_op(op);
        op = make_op(CMD_UMUL, '1, '1, 33);
        queue_op(op);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // three idling phases, the queue drained between them
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 83 : 0;
            recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 21 : 0;
            repeat (120) queue_op(random_op());
            while (pending_ops.size() != 0 || expected_results.size() != 0)
                @(posedge aclk);
            @(posedge aclk);
        end
        repeat (80) @(posedge aclk);
        $display("covered %0d operations over all opcodes, widths 0 to 127 and three",
                 ops_sent);
        $display("flow-control phases, %0d results checked", results_seen);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
